// ===== hdl/kmlc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmlc_pkg
// Shared types, codes and default sizes for the k-means clustering block.
// ----------------------------------------------------------------------------
package kmlc_pkg;

    localparam int DEF_MAX_POINTS   = 256;
    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_DIMENSIONS   = 4;

    localparam int COORD_W    = 16;
    localparam int IN_COORDS  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_DIST_W = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 2'd2;

    localparam logic [3:0] RST_CLUSTER_COUNT   = 4'd8;
    localparam logic [7:0] RST_ITERATION_LIMIT = 8'd32;
    localparam logic [8:0] RST_POINT_COUNT     = 9'd256;

    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_CENTROID = 2'd1,
        KIND_RUN      = 2'd2,
        KIND_CLASSIFY = 2'd3
    } kind_t;

    localparam logic RES_ROW   = 1'b0;
    localparam logic RES_CLASS = 1'b1;

    typedef struct packed {
        logic [1:0]                kind;
        logic [7:0]                slot;
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
        logic signed [COORD_W-1:0] coord_2;
        logic signed [COORD_W-1:0] coord_3;
    } in_item_t;

    typedef struct packed {
        logic                      result_kind;
        logic [2:0]                cluster;
        logic signed [COORD_W-1:0] out_0;
        logic signed [COORD_W-1:0] out_1;
        logic signed [COORD_W-1:0] out_2;
        logic signed [COORD_W-1:0] out_3;
        logic [OUT_DIST_W-1:0]     distance;
        logic [7:0]                iterations_used;
        logic                      last;
    } out_item_t;

    // Per-lane strobes from the sequencer.
    typedef struct packed {
        logic cent_load;
        logic cent_upd;
        logic acc_clr;
        logic acc_en;
    } lane_ctrl_t;

endpackage

// ===== hdl/kmlc_chan_if.sv =====
// ----------------------------------------------------------------------------
// kmlc_chan_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface kmlc_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/kmlc_lane.sv =====
// ----------------------------------------------------------------------------
// kmlc_lane
// One cluster lane: holds its centroid, forms the squared distance to the
// current point in two register stages and accumulates its members.
// ----------------------------------------------------------------------------
module kmlc_lane #(
    parameter int DIMENSIONS = kmlc_pkg::DEF_DIMENSIONS,
    parameter int SUM_W      = 24,
    parameter int CNT_W      = 9,
    parameter int DIST_W     = 36,
    parameter int DIM_W      = 2
) (
    input  logic                                clk,
    input  kmlc_pkg::lane_ctrl_t                ctrl,
    input  logic signed [kmlc_pkg::COORD_W-1:0] point    [DIMENSIONS],
    input  logic signed [kmlc_pkg::COORD_W-1:0] load_vec [DIMENSIONS],
    input  logic [DIM_W-1:0]                    upd_dim,
    input  logic signed [kmlc_pkg::COORD_W-1:0] upd_val,
    output logic [DIST_W-1:0]                   sq_sum,
    output logic signed [kmlc_pkg::COORD_W-1:0] cent     [DIMENSIONS],
    output logic signed [SUM_W-1:0]             acc_sum  [DIMENSIONS],
    output logic [CNT_W-1:0]                    count
);
    import kmlc_pkg::*;

    logic signed [COORD_W-1:0] cent_reg  [DIMENSIONS];
    logic [2*COORD_W+1:0]      sq_reg    [DIMENSIONS];
    logic [2*COORD_W+1:0]      sq_next   [DIMENSIONS];
    logic [DIST_W-1:0]         dist_reg;
    logic [DIST_W-1:0]         dist_next;
    logic signed [SUM_W-1:0]   sum_reg   [DIMENSIONS];
    logic [CNT_W-1:0]          count_reg;

    always_comb
    begin
        logic signed [COORD_W:0]     diff;
        logic signed [2*COORD_W+1:0] prod;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            diff       = {point[d][COORD_W-1], point[d]} - {cent_reg[d][COORD_W-1], cent_reg[d]};
            prod       = diff * diff;
            sq_next[d] = prod;
        end
    end

    always_comb
    begin
        dist_next = '0;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            dist_next = dist_next + DIST_W'(sq_reg[d]);
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        dist_reg <= dist_next;
        if (ctrl.cent_load)
        begin
            cent_reg <= load_vec;
        end
        else if (ctrl.cent_upd)
        begin
            cent_reg[upd_dim] <= upd_val;
        end
        if (ctrl.acc_clr)
        begin
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                sum_reg[d] <= '0;
            end
            count_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                sum_reg[d] <= sum_reg[d] + SUM_W'(point[d]);
            end
            count_reg <= count_reg + 1'b1;
        end
    end

    assign sq_sum  = dist_reg;
    assign cent    = cent_reg;
    assign acc_sum = sum_reg;
    assign count   = count_reg;

endmodule

// ===== hdl/kmlc_merge.sv =====
// ----------------------------------------------------------------------------
// kmlc_merge
// Walks the lane distances one per cycle and keeps the smallest; the lower
// index wins a tie.
// ----------------------------------------------------------------------------
module kmlc_merge #(
    parameter int LANES  = kmlc_pkg::DEF_MAX_CLUSTERS,
    parameter int DIST_W = 36,
    parameter int IDX_W  = 3,
    parameter int KCNT_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KCNT_W-1:0] k,
    input  logic [DIST_W-1:0] lane_dist [LANES],
    output logic              done,
    output logic [IDX_W-1:0]  best_idx,
    output logic [DIST_W-1:0] best_dist
);
    import kmlc_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [KCNT_W-1:0] idx_reg;
    logic [KCNT_W-1:0] idx_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [DIST_W-1:0] best_dist_reg;
    logic [DIST_W-1:0] best_dist_next;

    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = 1'b0;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (start)
        begin
            busy_next      = 1'b1;
            idx_next       = KCNT_W'(1);
            best_idx_next  = '0;
            best_dist_next = lane_dist[0];
        end
        else if (busy_reg)
        begin
            if (idx_reg >= k)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (lane_dist[idx_reg[IDX_W-1:0]] < best_dist_reg)
                begin
                    best_dist_next = lane_dist[idx_reg[IDX_W-1:0]];
                    best_idx_next  = idx_reg[IDX_W-1:0];
                end
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    assign done      = done_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

// ===== hdl/kmlc_div.sv =====
// ----------------------------------------------------------------------------
// kmlc_div
// Restoring divider, one quotient bit per cycle: signed sum over unsigned
// member count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module kmlc_div #(
    parameter int SUM_W = 24,
    parameter int CNT_W = 9
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [SUM_W-1:0]             dividend,
    input  logic [CNT_W-1:0]                    divisor,
    output logic                                done,
    output logic signed [kmlc_pkg::COORD_W-1:0] quotient
);
    import kmlc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W:0]    rem_next;
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  div_next;
    logic              neg_reg;
    logic              neg_next;
    logic [CNT_W:0]    trial;
    logic [SUM_W-1:0]  signed_q;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            rem_next  = '0;
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            div_next  = divisor;
            neg_next  = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign signed_q = neg_reg ? -quo_reg : quo_reg;
    assign quotient = signed_q[COORD_W-1:0];
    assign done     = done_reg;

endmodule

// ===== hdl/kmeans_lloyd_clustering_top.sv =====
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering_top
// Lloyd k-means over loaded points and loaded starting centroids.
// ----------------------------------------------------------------------------
// Loads give no result. For a classify item (k clusters in use) every cluster
// lane forms its distance in two register stages and the merge unit then
// scans the lanes one per cycle. A run repeats passes over the n points in
// use; each point goes through the point memory read, the lanes and the
// merge scan, and a pass that changes an assignment is followed by the
// shared divider, which divides each coordinate of every non-empty cluster.
// The k centroid rows then leave one per cycle as the output side takes them.
// Input items are taken only while no item is at work; a finished result
// may still wait in the output register.
// ----------------------------------------------------------------------------
module kmeans_lloyd_clustering_top #(
    parameter int MAX_POINTS   = kmlc_pkg::DEF_MAX_POINTS,
    parameter int MAX_CLUSTERS = kmlc_pkg::DEF_MAX_CLUSTERS,
    parameter int DIMENSIONS   = kmlc_pkg::DEF_DIMENSIONS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kmlc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmlc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    kmlc_chan_if.sink                         in_ch,
    kmlc_chan_if.source                       out_ch
);
    import kmlc_pkg::*;

    localparam int PIDX_W = $clog2(MAX_POINTS);
    localparam int NCNT_W = $clog2(MAX_POINTS + 1);
    localparam int CIDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KCNT_W = $clog2(MAX_CLUSTERS + 1);
    localparam int DIM_W  = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int SUM_W  = COORD_W + PIDX_W;
    localparam int DIST_W = OUT_DIST_W + $clog2(DIMENSIONS);
    localparam int ROW_W  = DIMENSIONS * COORD_W;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_LANE     = 10'b00_0000_0010,
        ST_MERGE    = 10'b00_0000_0100,
        ST_CLS_OUT  = 10'b00_0000_1000,
        ST_PASS     = 10'b00_0001_0000,
        ST_READ     = 10'b00_0010_0000,
        ST_UPD      = 10'b00_0100_0000,
        ST_DIV_SEL  = 10'b00_1000_0000,
        ST_DIV_WAIT = 10'b01_0000_0000,
        ST_EMIT     = 10'b10_0000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              run_mode_reg;
    logic              run_mode_next;
    logic              first_reg;
    logic              first_next;
    logic              changed_reg;
    logic              changed_next;
    logic [1:0]        wcnt_reg;
    logic [1:0]        wcnt_next;
    logic [NCNT_W-1:0] i_reg;
    logic [NCNT_W-1:0] i_next;
    logic [KCNT_W-1:0] c_reg;
    logic [KCNT_W-1:0] c_next;
    logic [DIM_W-1:0]  d_reg;
    logic [DIM_W-1:0]  d_next;
    logic [7:0]        iter_reg;
    logic [7:0]        iter_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;

    logic [3:0]        cluster_count_reg;
    logic [7:0]        iteration_limit_reg;
    logic [8:0]        point_count_reg;

    logic [ROW_W-1:0]  pt_mem [MAX_POINTS];
    logic [CIDX_W-1:0] asg_mem [MAX_POINTS];
    logic [ROW_W-1:0]  pt_rdata_reg;
    logic [CIDX_W-1:0] asg_rdata_reg;

    logic signed [COORD_W-1:0] cls_vec_reg [DIMENSIONS];
    logic signed [COORD_W-1:0] in_vec      [DIMENSIONS];
    logic signed [COORD_W-1:0] rd_vec      [DIMENSIONS];
    logic signed [COORD_W-1:0] lane_pt     [DIMENSIONS];
    logic signed [COORD_W-1:0] in_coord    [IN_COORDS];
    logic signed [COORD_W-1:0] row_coord   [IN_COORDS];
    logic [ROW_W-1:0]          pt_wdata;

    logic [DIST_W-1:0]         lane_dist [MAX_CLUSTERS];
    logic signed [COORD_W-1:0] lane_cent [MAX_CLUSTERS][DIMENSIONS];
    logic signed [SUM_W-1:0]   lane_sum  [MAX_CLUSTERS][DIMENSIONS];
    logic [NCNT_W-1:0]         lane_cnt  [MAX_CLUSTERS];
    lane_ctrl_t                lane_ctrl [MAX_CLUSTERS];

    logic              in_fire;
    logic              rd_en;
    logic              merge_start;
    logic              merge_done;
    logic [CIDX_W-1:0] best_idx;
    logic [DIST_W-1:0] best_dist;
    logic              div_start;
    logic              div_done;
    logic signed [COORD_W-1:0] div_q;
    logic              acc_clr;
    logic              upd_fire;
    logic              out_free;
    logic              pass_differ;
    logic [KCNT_W-1:0] k_use;
    logic [NCNT_W-1:0] n_use;
    logic [CIDX_W-1:0] c_idx;
    logic [CIDX_W-1:0] row_sel;
    logic [CIDX_W-1:0] old_asg;
    logic              pt_load;
    logic              cent_load;

    // ------------------------------------------------------------------
    // Configuration and derived counts
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg   <= RST_CLUSTER_COUNT;
            iteration_limit_reg <= RST_ITERATION_LIMIT;
            point_count_reg     <= RST_POINT_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLUSTER_COUNT:   cluster_count_reg   <= cfg_wdata[3:0];
                CFG_ITERATION_LIMIT: iteration_limit_reg <= cfg_wdata[7:0];
                CFG_POINT_COUNT:     point_count_reg     <= cfg_wdata[8:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (cluster_count_reg == '0)
        begin
            k_use = KCNT_W'(1);
        end
        else if (32'(cluster_count_reg) > MAX_CLUSTERS)
        begin
            k_use = KCNT_W'(MAX_CLUSTERS);
        end
        else
        begin
            k_use = KCNT_W'(cluster_count_reg);
        end
        if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_use = NCNT_W'(MAX_POINTS);
        end
        else
        begin
            n_use = NCNT_W'(point_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking and point rows
    // ------------------------------------------------------------------
    assign in_coord[0] = in_ch.data.coord_0;
    assign in_coord[1] = in_ch.data.coord_1;
    assign in_coord[2] = in_ch.data.coord_2;
    assign in_coord[3] = in_ch.data.coord_3;

    always_comb
    begin
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            in_vec[d]                   = (d < IN_COORDS) ? in_coord[d] : '0;
            pt_wdata[d*COORD_W+:COORD_W] = in_vec[d];
            rd_vec[d]                   = pt_rdata_reg[d*COORD_W+:COORD_W];
            lane_pt[d]                  = run_mode_reg ? rd_vec[d] : cls_vec_reg[d];
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign pt_load     = in_fire && (in_ch.data.kind == KIND_POINT)
                         && (32'(in_ch.data.slot) < MAX_POINTS);
    assign cent_load   = in_fire && (in_ch.data.kind == KIND_CENTROID)
                         && (32'(in_ch.data.slot) < MAX_CLUSTERS);

    always_ff @(posedge clk)
    begin
        if (pt_load)
        begin
            pt_mem[PIDX_W'(in_ch.data.slot)] <= pt_wdata;
        end
        if (rd_en)
        begin
            pt_rdata_reg <= pt_mem[i_reg[PIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            asg_mem[i_reg[PIDX_W-1:0]] <= best_idx;
        end
        if (rd_en)
        begin
            asg_rdata_reg <= asg_mem[i_reg[PIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_ch.data.kind == KIND_CLASSIFY))
        begin
            cls_vec_reg <= in_vec;
        end
    end

    // ------------------------------------------------------------------
    // Cluster lanes
    // ------------------------------------------------------------------
    assign c_idx = c_reg[CIDX_W-1:0];

    for (genvar l = 0; l < MAX_CLUSTERS; l++)
    begin : g_lane
        always_comb
        begin
            lane_ctrl[l].cent_load = cent_load && (32'(in_ch.data.slot) == l);
            lane_ctrl[l].cent_upd  = (state_reg == ST_DIV_WAIT) && div_done
                                     && (32'(c_idx) == l);
            lane_ctrl[l].acc_clr   = acc_clr;
            lane_ctrl[l].acc_en    = upd_fire && (32'(best_idx) == l);
        end

        kmlc_lane #(
            .DIMENSIONS (DIMENSIONS),
            .SUM_W      (SUM_W),
            .CNT_W      (NCNT_W),
            .DIST_W     (DIST_W),
            .DIM_W      (DIM_W)
        ) u_lane (
            .clk      (clk),
            .ctrl     (lane_ctrl[l]),
            .point    (lane_pt),
            .load_vec (in_vec),
            .upd_dim  (d_reg),
            .upd_val  (div_q),
            .sq_sum   (lane_dist[l]),
            .cent     (lane_cent[l]),
            .acc_sum  (lane_sum[l]),
            .count    (lane_cnt[l])
        );
    end

    kmlc_merge #(
        .LANES  (MAX_CLUSTERS),
        .DIST_W (DIST_W),
        .IDX_W  (CIDX_W),
        .KCNT_W (KCNT_W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (merge_start),
        .k         (k_use),
        .lane_dist (lane_dist),
        .done      (merge_done),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    kmlc_div #(
        .SUM_W (SUM_W),
        .CNT_W (NCNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lane_sum[c_idx][d_reg]),
        .divisor  (lane_cnt[c_idx]),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free    = !out_valid_reg || out_ch.ready;
    // The first pass of a run compares against cleared assignments.
    assign old_asg     = first_reg ? '0 : asg_rdata_reg;
    assign pass_differ = (old_asg != best_idx);
    assign row_sel     = (state_reg == ST_CLS_OUT) ? best_idx : c_idx;

    always_comb
    begin
        for (int j = 0; j < IN_COORDS; j++)
        begin
            row_coord[j] = (j < DIMENSIONS) ? lane_cent[row_sel][j] : '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        run_mode_next  = run_mode_reg;
        first_next     = first_reg;
        changed_next   = changed_reg;
        wcnt_next      = wcnt_reg;
        i_next         = i_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        iter_next      = iter_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        merge_start    = 1'b0;
        div_start      = 1'b0;
        acc_clr        = 1'b0;
        upd_fire       = 1'b0;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;

        out_data_next.result_kind     = RES_ROW;
        out_data_next.cluster         = 3'(row_sel);
        out_data_next.out_0           = row_coord[0];
        out_data_next.out_1           = row_coord[1];
        out_data_next.out_2           = row_coord[2];
        out_data_next.out_3           = row_coord[3];
        out_data_next.distance        = '0;
        out_data_next.iterations_used = iter_reg;
        out_data_next.last            = (c_reg == k_use - 1'b1);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind_t'(in_ch.data.kind))
                        KIND_CLASSIFY:
                        begin
                            run_mode_next = 1'b0;
                            wcnt_next     = '0;
                            state_next    = ST_LANE;
                        end
                        KIND_RUN:
                        begin
                            run_mode_next = 1'b1;
                            first_next    = 1'b1;
                            iter_next     = '0;
                            state_next    = ST_PASS;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PASS:
            begin
                if ((iter_reg >= iteration_limit_reg) || (n_use == '0))
                begin
                    c_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    acc_clr      = 1'b1;
                    i_next       = '0;
                    changed_next = 1'b0;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                wcnt_next  = '0;
                state_next = ST_LANE;
            end
            ST_LANE:
            begin
                // Wait out the lane register stages, then the distances are ready.
                if (wcnt_reg == 2'd2)
                begin
                    merge_start = 1'b1;
                    state_next  = ST_MERGE;
                end
                else
                begin
                    wcnt_next = wcnt_reg + 1'b1;
                end
            end
            ST_MERGE:
            begin
                if (merge_done)
                begin
                    state_next = run_mode_reg ? ST_UPD : ST_CLS_OUT;
                end
            end
            ST_CLS_OUT:
            begin
                out_data_next.result_kind     = RES_CLASS;
                out_data_next.distance        = best_dist[OUT_DIST_W-1:0];
                out_data_next.iterations_used = '0;
                out_data_next.last            = 1'b1;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    out_data_next = out_data_reg;
                end
            end
            ST_UPD:
            begin
                upd_fire = 1'b1;
                if (pass_differ)
                begin
                    changed_next = 1'b1;
                end
                i_next = i_reg + 1'b1;
                if (NCNT_W'(i_reg + 1'b1) == n_use)
                begin
                    c_next = '0;
                    d_next = '0;
                    if (changed_reg || pass_differ)
                    begin
                        state_next = ST_DIV_SEL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DIV_SEL:
            begin
                if (c_reg == k_use)
                begin
                    iter_next  = iter_reg + 1'b1;
                    first_next = 1'b0;
                    state_next = ST_PASS;
                end
                else if (lane_cnt[c_idx] == '0)
                begin
                    // An empty cluster keeps its centroid.
                    c_next = c_reg + 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (d_reg == DIM_W'(DIMENSIONS - 1))
                    begin
                        d_next = '0;
                        c_next = c_reg + 1'b1;
                    end
                    else
                    begin
                        d_next = d_reg + 1'b1;
                    end
                    state_next = ST_DIV_SEL;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    c_next         = c_reg + 1'b1;
                    if (c_reg == k_use - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    out_data_next = out_data_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (!((state_reg == ST_CLS_OUT) || (state_reg == ST_EMIT)))
        begin
            out_data_next = out_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_mode_reg  <= 1'b0;
            first_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            wcnt_reg      <= '0;
            i_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_mode_reg  <= run_mode_next;
            first_reg     <= first_next;
            changed_reg   <= changed_next;
            wcnt_reg      <= wcnt_next;
            i_reg         <= i_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

`ifndef SYNTHESIS
    a_merge_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        merge_done |-> (state_reg == ST_MERGE))
        else $error("merge finished outside the merge state");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside the divide wait state");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (iter_reg <= iteration_limit_reg))
        else $error("run performed more updates than the iteration limit");

    a_class_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.result_kind == RES_CLASS)) |-> out_data_reg.last)
        else $error("classification answer without last");
`endif

endmodule
